// ===== rtl/dsp_pkg.sv =====
// Shared types, unit tables and lookup functions for the duration string parser.
package dsp_pkg;

	localparam int MAX_UNIT_LETTERS_DEF = 4;
	localparam int MUL_W                = 42;
	localparam int NUM_KEYS             = 15;

	typedef enum logic [1:0] {
		PH_BETWEEN = 2'd0,
		PH_NUMBER  = 2'd1,
		PH_UNIT    = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		U_NS   = 3'd0,
		U_US   = 3'd1,
		U_MS   = 3'd2,
		U_SEC  = 3'd3,
		U_MIN  = 3'd4,
		U_HOUR = 3'd5,
		U_DAY  = 3'd6,
		U_WEEK = 3'd7
	} unit_t;

	typedef enum logic [1:0] {
		BASE_NS  = 2'd0,
		BASE_US  = 2'd1,
		BASE_MS  = 2'd2,
		BASE_SEC = 2'd3
	} base_t;

	// Event leaving the parse stage: one token add and/or the string end.
	typedef struct packed {
		logic             term;
		logic             ok;
		logic [63:0]      num;
		logic [MUL_W-1:0] mul;
	} evt_t;

	// Partial products of num * mul, modulo 2^64.
	typedef struct packed {
		logic        term;
		logic        ok;
		logic [63:0] p_ll;
		logic [31:0] p_x1;
		logic [31:0] p_x2;
	} part_t;

	typedef struct packed {
		logic        term;
		logic        ok;
		logic [63:0] prod;
	} prod_t;

	typedef struct packed {
		logic  hit;
		unit_t unit;
	} lookup_t;

	// Unit words, first letter in the low byte.
	localparam logic [31:0] KEY_WORD [NUM_KEYS] = '{
		32'h0000_736E, 32'h0000_7375, 32'h0000_736D,
		32'h0000_0073, 32'h0063_6573,
		32'h0000_006D, 32'h006E_696D,
		32'h0000_0068, 32'h0000_7268, 32'h7275_6F68,
		32'h0000_0064, 32'h0079_6164,
		32'h0000_0077, 32'h0000_6B77, 32'h6B65_6577
	};

	localparam logic [2:0] KEY_LEN [NUM_KEYS] = '{
		3'd2, 3'd2, 3'd2,
		3'd1, 3'd3,
		3'd1, 3'd3,
		3'd1, 3'd2, 3'd4,
		3'd1, 3'd3,
		3'd1, 3'd2, 3'd4
	};

	localparam unit_t KEY_UNIT [NUM_KEYS] = '{
		U_NS, U_US, U_MS,
		U_SEC, U_SEC,
		U_MIN, U_MIN,
		U_HOUR, U_HOUR, U_HOUR,
		U_DAY, U_DAY,
		U_WEEK, U_WEEK, U_WEEK
	};

	function automatic lookup_t unit_lookup(input logic [31:0] word, input logic [3:0] count);
		lookup_t     r;
		logic [31:0] mask;
		r = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			mask = '0;
			for (int j = 0; j < 4; j++) begin
				if (j < int'(KEY_LEN[i])) begin
					mask[j*8 +: 8] = 8'hFF;
				end
			end
			if ({1'b0, KEY_LEN[i]} == count && ((word ^ KEY_WORD[i]) & mask) == 32'h0) begin
				r.hit  = 1'b1;
				r.unit = KEY_UNIT[i];
			end
		end
		return r;
	endfunction

	// Multiplier of a unit in the table of a base; zero where the unit is absent.
	function automatic logic [MUL_W-1:0] unit_mul(input base_t base, input unit_t unit);
		logic [MUL_W-1:0] m;
		m = '0;
		case (base)
			BASE_NS: begin
				case (unit)
					U_NS:    m = MUL_W'(64'd1);
					U_US:    m = MUL_W'(64'd1000);
					U_MS:    m = MUL_W'(64'd1000000);
					U_SEC:   m = MUL_W'(64'd1000000000);
					U_MIN:   m = MUL_W'(64'd60000000000);
					U_HOUR:  m = MUL_W'(64'd3600000000000);
					default: m = '0;
				endcase
			end
			BASE_US: begin
				case (unit)
					U_US:    m = MUL_W'(64'd1);
					U_MS:    m = MUL_W'(64'd1000);
					U_SEC:   m = MUL_W'(64'd1000000);
					U_MIN:   m = MUL_W'(64'd60000000);
					U_HOUR:  m = MUL_W'(64'd3600000000);
					U_DAY:   m = MUL_W'(64'd86400000000);
					default: m = '0;
				endcase
			end
			BASE_MS: begin
				case (unit)
					U_MS:    m = MUL_W'(64'd1);
					U_SEC:   m = MUL_W'(64'd1000);
					U_MIN:   m = MUL_W'(64'd60000);
					U_HOUR:  m = MUL_W'(64'd3600000);
					U_DAY:   m = MUL_W'(64'd86400000);
					U_WEEK:  m = MUL_W'(64'd604800000);
					default: m = '0;
				endcase
			end
			BASE_SEC: begin
				case (unit)
					U_SEC:   m = MUL_W'(64'd1);
					U_MIN:   m = MUL_W'(64'd60);
					U_HOUR:  m = MUL_W'(64'd3600);
					U_DAY:   m = MUL_W'(64'd86400);
					U_WEEK:  m = MUL_W'(64'd604800);
					default: m = '0;
				endcase
			end
			default: m = '0;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/duration_string_parser_top.sv =====
// Top level of the duration string parser: register, parse, multiply and accumulate stages.
//
// Feed one string character per request on ch; byte 0 ends the string and yields exactly
// one result (status 0 and the summed duration in base units, or status 1 and zero on a
// format error). Other characters yield no result. The block takes one character every
// clock cycle while in_stall is low; a terminator's result passes from the parse register
// through the partial-product register and the product register into the result
// register. The parse state machine and digit accumulator settle each character, and
// the token multiply (a 64-bit count times a table multiplier of up to 42 bits, kept
// modulo 2^64) runs in two pipelined stages behind it. A stall on the result side only
// backs up into in_stall once the three pipeline stages and the result register are
// all occupied.
// base_unit selects the result unit and the accepted unit words (0 ns, 1 us, 2 ms,
// 3 seconds); write it through wr_en/wr_data only while no string is in flight.
// There is no memory and no clearing pass after reset.
module duration_string_parser_top #(
	parameter int MAX_UNIT_LETTERS = dsp_pkg::MAX_UNIT_LETTERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  ch,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        status,
	output logic [63:0] total
);
	import dsp_pkg::*;

	base_t base_unit_q;
	logic  evt_v;
	evt_t  evt;
	logic  mul_free;
	logic  prod_v;
	prod_t prod;
	logic  prod_take;

	// hold the unit selection until the next write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_unit_q <= BASE_NS;
		end else if (wr_en) begin
			base_unit_q <= base_t'(wr_data);
		end
	end

	// parse each character; emit a request only for a token add or the terminator
	dsp_parse #(
		.MAX_UNIT_LETTERS(MAX_UNIT_LETTERS)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.base_unit (base_unit_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.evt_v     (evt_v),
		.evt       (evt),
		.next_free (mul_free)
	);

	// form count times multiplier over two stages
	dsp_mul u_mul (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_v     (evt_v),
		.evt       (evt),
		.in_free   (mul_free),
		.prod_v    (prod_v),
		.prod      (prod),
		.prod_take (prod_take)
	);

	// add into the running total and drop the result into the output register
	dsp_accum u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.prod_v    (prod_v),
		.prod      (prod),
		.prod_take (prod_take),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.total     (total)
	);

endmodule

// ===== rtl/dsp_parse.sv =====
// Character parse stage: token state machine, digit accumulator and unit lookup.
module dsp_parse #(
	parameter int MAX_UNIT_LETTERS = dsp_pkg::MAX_UNIT_LETTERS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  dsp_pkg::base_t base_unit,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     ch,
	output logic           evt_v,
	output dsp_pkg::evt_t  evt,
	input  logic           next_free
);
	import dsp_pkg::*;

	localparam int CNT_W = $clog2(MAX_UNIT_LETTERS + 1);
	localparam int IDX_W = $clog2(MAX_UNIT_LETTERS);

	phase_t           phase_q, phase_d;
	logic [63:0]      acc_q, acc_d;
	logic [7:0]       letters_q [MAX_UNIT_LETTERS];
	logic [7:0]       letters_d [MAX_UNIT_LETTERS];
	logic [CNT_W-1:0] count_q, count_d;
	logic             too_long_q, too_long_d;
	logic             any_q, any_d;

	logic             vld_s1;
	evt_t             evt_s1;
	logic             s1_free;
	logic             accept;
	logic             is_digit, is_letter, is_space, is_term;
	logic [3:0]       dval;
	logic [67:0]      acc_wide;
	logic [63:0]      acc_next;
	lookup_t          lk;
	logic [MUL_W-1:0] mul_v;
	logic             fin_ok;
	logic             add_en;
	logic             term_ok;
	logic             emit;
	evt_t             evt_c;

	assign s1_free  = !vld_s1 || next_free;
	assign accept   = in_valid && s1_free;
	assign in_stall = !s1_free;

	assign is_term   = (ch == 8'h00);
	assign is_digit  = ch inside {[8'h30:8'h39]};
	assign is_letter = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
	assign is_space  = ch inside {8'h20, [8'h09:8'h0D]};
	assign dval      = ch[3:0];

	// times ten plus digit, saturating at all ones
	assign acc_wide = ({4'h0, acc_q} << 3) + ({4'h0, acc_q} << 1) + 68'(dval);
	assign acc_next = (acc_wide[67:64] != 4'h0) ? '1 : acc_wide[63:0];

	assign lk     = unit_lookup({letters_q[3], letters_q[2], letters_q[1], letters_q[0]},
		4'(count_q));
	assign mul_v  = unit_mul(base_unit, lk.unit);
	assign fin_ok = !too_long_q && lk.hit && (mul_v != '0);

	// next parse state
	always_comb begin
		phase_d    = phase_q;
		acc_d      = acc_q;
		letters_d  = letters_q;
		count_d    = count_q;
		too_long_d = too_long_q;
		any_d      = any_q;
		if (accept) begin
			if (is_term) begin
				phase_d    = PH_BETWEEN;
				acc_d      = '0;
				count_d    = '0;
				too_long_d = 1'b0;
				any_d      = 1'b0;
			end else begin
				case (phase_q)
					PH_BETWEEN: begin
						if (is_space) begin
							phase_d = PH_BETWEEN;
						end else if (is_digit) begin
							acc_d   = 64'(dval);
							phase_d = PH_NUMBER;
						end else begin
							phase_d = PH_ERROR;
						end
					end
					PH_NUMBER: begin
						if (is_digit) begin
							acc_d = acc_next;
						end else if (is_letter) begin
							letters_d[0] = ch;
							count_d      = CNT_W'(1);
							too_long_d   = 1'b0;
							phase_d      = PH_UNIT;
						end else begin
							phase_d = PH_ERROR;
						end
					end
					PH_UNIT: begin
						if (is_letter) begin
							if (count_q < CNT_W'(MAX_UNIT_LETTERS)) begin
								letters_d[count_q[IDX_W-1:0]] = ch;
								count_d = count_q + CNT_W'(1);
							end else begin
								too_long_d = 1'b1;
							end
						end else if (fin_ok) begin
							any_d = 1'b1;
							acc_d = '0;
							if (is_space) begin
								phase_d = PH_BETWEEN;
							end else if (is_digit) begin
								acc_d   = 64'(dval);
								phase_d = PH_NUMBER;
							end else begin
								phase_d = PH_ERROR;
							end
						end else begin
							phase_d = PH_ERROR;
						end
					end
					default: phase_d = phase_q;
				endcase
			end
		end
	end

	// event for the multiply stages
	always_comb begin
		add_en  = 1'b0;
		term_ok = 1'b0;
		case (phase_q)
			PH_UNIT: begin
				add_en  = is_term || !is_letter ? fin_ok : 1'b0;
				term_ok = fin_ok;
			end
			PH_BETWEEN: term_ok = any_q;
			default: begin
				add_en  = 1'b0;
				term_ok = 1'b0;
			end
		endcase
		emit      = accept && (add_en || is_term);
		evt_c.term = is_term;
		evt_c.ok   = term_ok;
		evt_c.num  = add_en ? acc_q : '0;
		evt_c.mul  = add_en ? mul_v : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_BETWEEN;
			acc_q      <= '0;
			count_q    <= '0;
			too_long_q <= 1'b0;
			any_q      <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			phase_q    <= phase_d;
			acc_q      <= acc_d;
			count_q    <= count_d;
			too_long_q <= too_long_d;
			any_q      <= any_d;
			if (s1_free) begin
				vld_s1 <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		letters_q <= letters_d;
		if (s1_free) begin
			evt_s1 <= evt_c;
		end
	end

	assign evt_v = vld_s1;
	assign evt   = evt_s1;

endmodule

// ===== rtl/dsp_mul.sv =====
// Two-stage multiplier: 32-bit partial products, then their sum modulo 2^64.
module dsp_mul (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           evt_v,
	input  dsp_pkg::evt_t  evt,
	output logic           in_free,
	output logic           prod_v,
	output dsp_pkg::prod_t prod,
	input  logic           prod_take
);
	import dsp_pkg::*;

	localparam int MUL_HI_W = MUL_W - 32;

	logic        vld_s2, vld_s3;
	part_t       part_s2;
	prod_t       prod_s3;
	part_t       part_c;
	prod_t       prod_c;
	logic        s2_free, s3_free;
	logic [31:0] a_lo, a_hi, m_lo;
	logic [63:0] x1_full, x2_full;

	assign s3_free = !vld_s3 || prod_take;
	assign s2_free = !vld_s2 || s3_free;
	assign in_free = s2_free;

	assign a_lo    = evt.num[31:0];
	assign a_hi    = evt.num[63:32];
	assign m_lo    = evt.mul[31:0];
	assign x1_full = {32'h0, a_hi} * {32'h0, m_lo};
	assign x2_full = {32'h0, a_lo} * {{(64 - MUL_HI_W){1'b0}}, evt.mul[MUL_W-1:32]};

	always_comb begin
		part_c.term = evt.term;
		part_c.ok   = evt.ok;
		part_c.p_ll = {32'h0, a_lo} * {32'h0, m_lo};
		part_c.p_x1 = x1_full[31:0];
		part_c.p_x2 = x2_full[31:0];
	end

	always_comb begin
		prod_c.term = part_s2.term;
		prod_c.ok   = part_s2.ok;
		prod_c.prod = part_s2.p_ll + {part_s2.p_x1 + part_s2.p_x2, 32'h0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			if (s2_free) begin
				vld_s2 <= evt_v;
			end
			if (s3_free) begin
				vld_s3 <= vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			part_s2 <= part_c;
		end
		if (s3_free) begin
			prod_s3 <= prod_c;
		end
	end

	assign prod_v = vld_s3;
	assign prod   = prod_s3;

endmodule

// ===== rtl/dsp_accum.sv =====
// Running total accumulator and result register.
module dsp_accum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           prod_v,
	input  dsp_pkg::prod_t prod,
	output logic           prod_take,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           status,
	output logic [63:0]    total
);
	import dsp_pkg::*;

	logic [63:0] total_q;
	logic [63:0] sum;
	logic        vld_q;
	logic        status_q;
	logic [63:0] result_q;
	logic        out_free;

	assign out_free  = !vld_q || !out_stall;
	assign prod_take = prod_v && (!prod.term || out_free);
	assign sum       = total_q + prod.prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			vld_q   <= 1'b0;
		end else begin
			if (prod_take) begin
				total_q <= prod.term ? '0 : sum;
			end
			if (prod_take && prod.term) begin
				vld_q <= 1'b1;
			end else if (out_free) begin
				vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (prod_take && prod.term) begin
			status_q <= !prod.ok;
			result_q <= prod.ok ? sum : '0;
		end
	end

	assign out_valid = vld_q;
	assign status    = status_q;
	assign total     = result_q;

endmodule

// ===== tb/sv/duration_string_parser_top_tb.sv =====
// Self-checking testbench for the duration string parser top level.
`timescale 1ns / 100ps

module duration_string_parser_top_tb;
	import dsp_pkg::*;

	localparam int  CYCLE_LIMIT    = 400000;
	localparam int  DRAIN_CYCLES   = 8;
	localparam int  LONG_HOLD      = 400;
	localparam int  PHASE_CHARS    = 160;
	localparam int  RANDOM_PHASES  = 10;
	localparam int  MAX_REPORTS    = 30;
	localparam int  DIR_ROWS       = 22;
	localparam int  LETTERS        = MAX_UNIT_LETTERS_DEF;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

	// one result of the block: format error flag and summed duration
	typedef struct packed {
		logic        bad;
		logic [63:0] sum;
	} outcome_t;

	// result typed in by hand for a directed string, where known is set
	typedef struct packed {
		logic     known;
		outcome_t value;
	} pinned_t;

	typedef struct {
		string text;
		base_t base;
		bit    known;
		bit    bad;
		logic [63:0] sum;
	} vector_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        wr_en = 1'b0;
	logic [1:0]  wr_data = 2'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  ch = 8'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        status;
	logic [63:0] total;

	duration_string_parser_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_data   (wr_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.total     (total)
	);

	// 20 ns clock period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Directed strings: extremes, every unit word, each kind of format error.
	vector_t directed [DIR_ROWS] = '{
		'{"",                                    BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"\011\012\013\014\015 ",               BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"1ns",                                 BASE_NS,  1'b1, 1'b0, 64'd1},
		'{"18446744073709551615ns",              BASE_NS,  1'b1, 1'b0, ALL_ONES},
		'{"99999999999999999999ns",              BASE_NS,  1'b1, 1'b0, ALL_ONES},
		'{"1us 1ms\0111s 1sec1m 1min 1h 1hr 1hour", BASE_NS, 1'b0, 1'b0, 64'd0},
		'{"5",                                   BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"5 ns",                                BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"x5ns",                                BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"ns",                                  BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"5xs",                                 BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"5hours",                              BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"5Ns",                                 BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"1d",                                  BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"3ns\377 4ns",                         BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"2ns,\200!9",                          BASE_NS,  1'b1, 1'b1, 64'd0},
		'{"1w 1wk 1week 1d 1day",                BASE_SEC, 1'b0, 1'b0, 64'd0},
		'{"1ns",                                 BASE_SEC, 1'b1, 1'b1, 64'd0},
		'{"18446744073709551615week",            BASE_SEC, 1'b0, 1'b0, 64'd0},
		'{"7d12h  10us",                         BASE_US,  1'b0, 1'b0, 64'd0},
		'{"  10us  ",                            BASE_US,  1'b1, 1'b0, 64'd10},
		'{"0ms1w3d",                             BASE_MS,  1'b0, 1'b0, 64'd0}
	};

	string unit_words [15] = '{
		"ns", "us", "ms", "s", "sec", "m", "min", "h", "hr", "hour",
		"d", "day", "w", "wk", "week"
	};
	unit_t unit_kinds [15] = '{
		U_NS, U_US, U_MS, U_SEC, U_SEC, U_MIN, U_MIN, U_HOUR, U_HOUR, U_HOUR,
		U_DAY, U_DAY, U_WEEK, U_WEEK, U_WEEK
	};

	// Parser mirror, owned by the checker process below.
	base_t       cfg_base;
	phase_t      ph;
	logic [63:0] num_acc;
	logic [7:0]  unit_chars [LETTERS];
	int          unit_len;
	bit          unit_long;
	logic [63:0] acc_total;
	bit          seen_token;

	outcome_t    due_results [$];
	pinned_t     pinned_results [$];
	logic [7:0]  text [$];

	int errors;
	int results_seen;
	int chars_taken;
	int chars_sent;
	int cycle_count;
	int idle_pct;
	int stall_pct;
	bit hold_req;
	bit hold_ack;
	int hold_left;

	initial begin
		errors       = 0;
		results_seen = 0;
		chars_taken  = 0;
		chars_sent   = 0;
		cycle_count  = 0;
		idle_pct     = 0;
		stall_pct    = 0;
		hold_req     = 1'b0;
		hold_ack     = 1'b0;
		hold_left    = 0;
	end

	function automatic bit is_num(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic bit is_blank(logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// length of one unit in nanoseconds
	function automatic logic [63:0] ns_in(unit_t u);
		case (u)
			U_NS:    return 64'd1;
			U_US:    return 64'd1_000;
			U_MS:    return 64'd1_000_000;
			U_SEC:   return 64'd1_000_000_000;
			U_MIN:   return 64'd60_000_000_000;
			U_HOUR:  return 64'd3_600_000_000_000;
			U_DAY:   return 64'd86_400_000_000_000;
			default: return 64'd604_800_000_000_000;
		endcase
	endfunction

	function automatic void clear_parse();
		ph         = PH_BETWEEN;
		num_acc    = '0;
		unit_chars = '{default: 8'd0};
		unit_len   = 0;
		unit_long  = 1'b0;
		acc_total  = '0;
		seen_token = 1'b0;
	endfunction

	// Close a token: look the word up in the current table and add number * rate.
	// A table holds the base unit and up to five units above it (four above seconds).
	function automatic bit close_token();
		logic [31:0] word;
		unit_t       kind;
		bit          found;
		if (unit_long) begin
			return 1'b0;
		end
		word  = '0;
		found = 1'b1;
		kind  = U_NS;
		for (int i = 0; i < unit_len; i++) begin
			word = {word[23:0], unit_chars[i]};
		end
		case (word)
			"ns":                kind = U_NS;
			"us":                kind = U_US;
			"ms":                kind = U_MS;
			"s", "sec":          kind = U_SEC;
			"m", "min":          kind = U_MIN;
			"h", "hr", "hour":   kind = U_HOUR;
			"d", "day":          kind = U_DAY;
			"w", "wk", "week":   kind = U_WEEK;
			default:             found = 1'b0;
		endcase
		if (!found || int'(kind) < int'(cfg_base) || int'(kind) > int'(cfg_base) + 5) begin
			return 1'b0;
		end
		acc_total  = acc_total + num_acc * (ns_in(kind) / ns_in(unit_t'(cfg_base)));
		seen_token = 1'b1;
		return 1'b1;
	endfunction

	// Character where a token may start.
	function automatic void open_token(logic [7:0] c);
		if (is_blank(c)) begin
			ph = PH_BETWEEN;
		end else if (is_num(c)) begin
			num_acc = 64'(c - "0");
			ph      = PH_NUMBER;
		end else begin
			ph = PH_ERROR;
		end
	endfunction

	function automatic void take_letter(logic [7:0] c);
		if (unit_len < LETTERS) begin
			unit_chars[unit_len] = c;
			unit_len = unit_len + 1;
		end else begin
			unit_long = 1'b1;
		end
	endfunction

	// Advance the parser mirror by one character; the terminator yields a result.
	function automatic void scan_char(logic [7:0] c, output bit done, output outcome_t res);
		logic [67:0] wide;
		bit          ok;
		done = 1'b0;
		res  = '0;
		if (c == 8'd0) begin
			done = 1'b1;
			case (ph)
				PH_UNIT:    ok = close_token() && seen_token;
				PH_BETWEEN: ok = seen_token;
				default:    ok = 1'b0;
			endcase
			res.bad = !ok;
			res.sum = ok ? acc_total : 64'd0;
			clear_parse();
			return;
		end
		case (ph)
			PH_BETWEEN: open_token(c);
			PH_NUMBER: begin
				if (is_num(c)) begin
					// saturate at 2^64-1 like strtoul
					wide = 68'(num_acc) * 68'd10 + 68'(c - "0");
					num_acc = (wide[67:64] != 4'd0) ? ALL_ONES : wide[63:0];
				end else if (is_alpha(c)) begin
					unit_chars = '{default: 8'd0};
					unit_len   = 0;
					unit_long  = 1'b0;
					take_letter(c);
					ph = PH_UNIT;
				end else begin
					ph = PH_ERROR;
				end
			end
			PH_UNIT: begin
				if (is_alpha(c)) begin
					take_letter(c);
				end else if (close_token()) begin
					num_acc = '0;
					open_token(c);
				end else begin
					ph = PH_ERROR;
				end
			end
			default: ;
		endcase
	endfunction

	// Checker: compare each accepted result with the oldest expectation, then
	// mirror each accepted request and config write. Everything is sampled at
	// the rising edge, before the block's registers update.
	always @(posedge clk) begin
		outcome_t want;
		pinned_t  pin;
		bit       done;
		if (!arst_n) begin
			cfg_base = BASE_NS;
			clear_parse();
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (due_results.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS) begin
						$display("%0t: result with none expected, actual status %0d total %0d",
							$time, status, total);
					end
				end else begin
					want = due_results.pop_front();
					if (status !== want.bad) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: status mismatch, expected %0d, actual %0d",
								$time, want.bad, status);
						end
					end
					if (total !== want.sum) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: total mismatch, expected %0d, actual %0d",
								$time, want.sum, total);
						end
					end
				end
			end
			if (wr_en) begin
				cfg_base = base_t'(wr_data);
			end
			if (in_valid && !in_stall) begin
				chars_taken++;
				scan_char(ch, done, want);
				if (done) begin
					// a hand-typed result overrides the mirror for directed strings
					if (pinned_results.size() != 0) begin
						pin = pinned_results.pop_front();
						if (pin.known) begin
							want = pin.value;
						end
					end
					due_results.push_back(want);
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off counted here on request.
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else if (hold_req != hold_ack) begin
			hold_ack  = hold_req;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, due_results.size());
			$display("simulation failed");
			$finish;
		end
	end

	// Offer one character; hold it until the block takes the request.
	task automatic send_char(logic [7:0] c);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		ch       <= c;
		do begin
			@(posedge clk);
		end while (in_stall);
		chars_sent++;
		@(negedge clk);
	endtask

	// Send the composed text followed by the terminator.
	task automatic send_text();
		foreach (text[i]) begin
			send_char(text[i]);
		end
		send_char(8'd0);
	endtask

	// Drain all results and let the pipeline settle.
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(negedge clk);
		while (due_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Write base_unit while nothing is in flight.
	task automatic set_base(base_t b);
		wait_idle();
		wr_en   <= 1'b1;
		wr_data <= b;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic add_blanks();
		int n;
		n = ($urandom_range(99) < 60) ? 0 : $urandom_range(1, 2);
		repeat (n) begin
			case ($urandom_range(2))
				0:       text.push_back(8'd32);
				1:       text.push_back(8'd9);
				default: text.push_back(8'($urandom_range(9, 13)));
			endcase
		end
	endtask

	task automatic add_number();
		string digits;
		int    r;
		r = $urandom_range(99);
		if (r < 70) begin
			digits = $sformatf("%0d", $urandom_range(0, 999));
		end else if (r < 90) begin
			digits = $sformatf("%0d", $urandom);
		end else begin
			// long runs reach the wrap of the total and the saturation of the count
			digits = "";
			repeat ($urandom_range(15, 22)) text.push_back(8'($urandom_range(48, 57)));
		end
		for (int i = 0; i < digits.len(); i++) begin
			text.push_back(digits[i]);
		end
	endtask

	task automatic add_unit(base_t b);
		int    r;
		int    idx;
		string word;
		r = $urandom_range(99);
		if (r < 85) begin
			// mostly words from the table in force
			do begin
				idx = $urandom_range(0, 14);
			end while (int'(unit_kinds[idx]) < int'(b) || int'(unit_kinds[idx]) > int'(b) + 5);
			word = unit_words[idx];
		end else if (r < 93) begin
			word = unit_words[$urandom_range(0, 14)];
		end else if (r < 98) begin
			word = "";
			repeat ($urandom_range(1, 6)) begin
				text.push_back($urandom_range(1) ? 8'($urandom_range(65, 90))
					: 8'($urandom_range(97, 122)));
			end
		end else begin
			word = "";
		end
		for (int i = 0; i < word.len(); i++) begin
			text.push_back(word[i]);
		end
	endtask

	// Compose one random string: mostly well-formed sums, some broken, some noise.
	task automatic compose_random(base_t b);
		int kind;
		int pos;
		text.delete();
		kind = $urandom_range(99);
		if (kind < 5) begin
			repeat ($urandom_range(0, 12)) text.push_back(8'($urandom_range(1, 255)));
			return;
		end
		repeat ($urandom_range(1, 4)) begin
			add_blanks();
			add_number();
			add_unit(b);
		end
		add_blanks();
		if (kind >= 85 && text.size() != 0) begin
			pos = $urandom_range(0, text.size() - 1);
			case ($urandom_range(2))
				0:       text[pos] = 8'($urandom_range(1, 255));
				1:       text.insert(pos, 8'd32);
				default: text.delete(pos);
			endcase
		end
	endtask

	initial begin
		vector_t row;
		base_t   cur_base;
		int      mode;
		int      idle_of [5];
		int      stall_of [5];
		base_t   phase_base [RANDOM_PHASES];
		idle_of    = '{0, 71, 0, 36, 0};
		stall_of   = '{0, 0, 71, 36, 0};
		phase_base = '{BASE_SEC, BASE_NS, BASE_MS, BASE_US, BASE_NS,
			BASE_SEC, BASE_US, BASE_MS, BASE_SEC, BASE_NS};

		// hold reset, then release it at a falling edge
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// write the register once at its reset value
		cur_base = BASE_NS;
		set_base(cur_base);

		// directed strings, no idling
		foreach (directed[r]) begin
			row = directed[r];
			if (row.base != cur_base) begin
				cur_base = row.base;
				set_base(cur_base);
			end
			pinned_results.push_back('{row.known, '{row.bad, row.sum}});
			text.delete();
			for (int i = 0; i < row.text.len(); i++) begin
				text.push_back(row.text[i]);
			end
			send_text();
		end

		// random strings in phases of idling, output stalls and base unit
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			mode     = p % 5;
			cur_base = phase_base[p];
			set_base(cur_base);
			idle_pct  = idle_of[mode];
			stall_pct <= stall_of[mode];
			// pressure phase: hold off the output so the pipeline fills and stalls input
			if (mode == 4) begin
				hold_req <= !hold_req;
			end
			chars_sent = 0;
			while (chars_sent < PHASE_CHARS) begin
				compose_random(cur_base);
				send_text();
			end
		end

		stall_pct <= 0;
		wait_idle();
		$display("checked %0d results from %0d characters", results_seen, chars_taken);
		$display("covered all four base units, mixed idle and stall, long output holds");
		if (errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
